@@ hdl/tkis_pkg.sv @@
// tkis_pkg: shared types and constants for the two-key index sort.
// Payload structs, controller state encoding and controller/datapath links.
// No dependencies.
package tkis_pkg;

    localparam int FIELD_W       = 32;
    localparam int POS_W         = 6;
    localparam int MAX_ELEMS_DEF = 64;
    localparam int KEY_WIDTH_DEF = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] primary_key;
        logic signed [FIELD_W-1:0] secondary_key;
        logic                      last_element;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0] sorted_position;
        logic             last_rank;
    } out_t;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
        logic clear_idx;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
        logic last_one;
    } status_t;

endpackage

@@ hdl/tkis_ctrl.sv @@
// tkis_ctrl: load/emit controller of the two-key index sort.
// Drives handshakes and datapath commands; depends on tkis_pkg.
module tkis_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tkis_pkg::cmd_t    cmd,
    input  tkis_pkg::status_t status
);

    tkis_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tkis_pkg::ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            tkis_pkg::ST_LOAD: begin
                s_ready    = 1'b1;
                cmd.insert = s_valid && !status.full;
                if (s_valid && s_last) begin
                    state_next = tkis_pkg::ST_EMIT;
                end
            end
            tkis_pkg::ST_EMIT: begin
                cmd.shift_out = slot_free;
                if (slot_free && status.last_one) begin
                    cmd.clear_idx = 1'b1;
                    state_next    = tkis_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = tkis_pkg::ST_LOAD;
            end
        endcase
        m_valid_next = cmd.shift_out || (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;

    a_last_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> state_reg == tkis_pkg::ST_EMIT)
        else $error("last element did not start emission");

    a_emit_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tkis_pkg::ST_EMIT) |-> status.nonempty)
        else $error("emitting from an empty sorted row");

    a_final_rank_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_out && status.last_one) |=> (state_reg == tkis_pkg::ST_LOAD && m_valid_reg))
        else $error("final rank did not return to load");

endmodule

@@ hdl/tkis_datapath.sv @@
// tkis_datapath: sorted row of key/position cells with parallel insertion,
// shift-out toward cell 0 and the result register. Depends on tkis_pkg.
module tkis_datapath #(
    parameter int MAX_ELEMS = tkis_pkg::MAX_ELEMS_DEF,
    parameter int KEY_WIDTH = tkis_pkg::KEY_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tkis_pkg::in_t     s_payload,
    output tkis_pkg::out_t    m_payload,
    input  tkis_pkg::cmd_t    cmd,
    output tkis_pkg::status_t status
);

    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CK_W  = 2 * KEY_WIDTH;

    logic [KEY_WIDTH-1:0]      pk, sk;
    logic [CK_W-1:0]           new_key;
    logic [IDX_W-1:0]          idx_reg, idx_next;

    logic [CK_W-1:0]           key_reg  [MAX_ELEMS];
    logic [tkis_pkg::POS_W-1:0] pos_reg [MAX_ELEMS];
    logic [MAX_ELEMS-1:0]      vld_reg;
    logic [MAX_ELEMS-1:0]      le;
    logic [MAX_ELEMS-1:0]      prev_le, prev_vld, nxt_vld;
    logic [CK_W-1:0]           prev_key [MAX_ELEMS];
    logic [CK_W-1:0]           nxt_key  [MAX_ELEMS];
    logic [tkis_pkg::POS_W-1:0] prev_pos [MAX_ELEMS];
    logic [tkis_pkg::POS_W-1:0] nxt_pos  [MAX_ELEMS];

    logic [tkis_pkg::POS_W-1:0] out_pos_reg;
    logic                       out_last_reg;

    if (KEY_WIDTH <= tkis_pkg::FIELD_W) begin : g_trunc
        assign pk = s_payload.primary_key[KEY_WIDTH-1:0];
        assign sk = s_payload.secondary_key[KEY_WIDTH-1:0];
    end else begin : g_ext
        assign pk = {{(KEY_WIDTH-tkis_pkg::FIELD_W){1'b0}}, s_payload.primary_key};
        assign sk = {{(KEY_WIDTH-tkis_pkg::FIELD_W){1'b0}}, s_payload.secondary_key};
    end

    // flipped sign bits make the unsigned compare signed (KEY_WIDTH <= FIELD_W)
    assign new_key = {~pk[KEY_WIDTH-1], pk[KEY_WIDTH-2:0], ~sk[KEY_WIDTH-1], sk[KEY_WIDTH-2:0]};

    for (genvar k = 0; k < MAX_ELEMS; k++) begin : g_cell
        // earlier entries with equal keys hold lower positions, so they stay ahead
        assign le[k] = vld_reg[k] && (key_reg[k] <= new_key);
        if (k == 0) begin : g_first
            assign prev_le[k]  = 1'b1;
            assign prev_vld[k] = 1'b1;
            assign prev_key[k] = new_key;
            assign prev_pos[k] = (tkis_pkg::POS_W)'(idx_reg);
        end else begin : g_mid
            assign prev_le[k]  = le[k-1];
            assign prev_vld[k] = vld_reg[k-1];
            assign prev_key[k] = key_reg[k-1];
            assign prev_pos[k] = pos_reg[k-1];
        end
        if (k == MAX_ELEMS - 1) begin : g_tail
            assign nxt_vld[k] = 1'b0;
            assign nxt_key[k] = key_reg[k];
            assign nxt_pos[k] = pos_reg[k];
        end else begin : g_body
            assign nxt_vld[k] = vld_reg[k+1];
            assign nxt_key[k] = key_reg[k+1];
            assign nxt_pos[k] = pos_reg[k+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (cmd.insert) begin
                vld_reg[k] <= vld_reg[k] || prev_vld[k];
            end else if (cmd.shift_out) begin
                vld_reg[k] <= nxt_vld[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.insert) begin
                if (!le[k]) begin
                    if (prev_le[k]) begin
                        key_reg[k] <= new_key;
                        pos_reg[k] <= (tkis_pkg::POS_W)'(idx_reg);
                    end else begin
                        key_reg[k] <= prev_key[k];
                        pos_reg[k] <= prev_pos[k];
                    end
                end
            end else if (cmd.shift_out) begin
                key_reg[k] <= nxt_key[k];
                pos_reg[k] <= nxt_pos[k];
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.clear_idx) begin
            idx_next = '0;
        end else if (cmd.insert) begin
            idx_next = IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_out) begin
            out_pos_reg  <= pos_reg[0];
            out_last_reg <= !vld_reg[1];
        end
    end

    assign m_payload.sorted_position = out_pos_reg;
    assign m_payload.last_rank       = out_last_reg;

    assign status.full     = vld_reg[MAX_ELEMS-1];
    assign status.nonempty = vld_reg[0];
    assign status.last_one = vld_reg[0] && !vld_reg[1];

endmodule

@@ hdl/two_key_index_sort.sv @@
// two_key_index_sort: top level of the two-key index sort.
// Joins tkis_ctrl and tkis_datapath; depends on tkis_pkg.
//
// Usage: elements arrive on the s_ channel (valid/ready), one transaction
// per element, each carrying a primary key, a secondary key and a last flag.
// Every element that fits is inserted into a sorted row of cells in the cycle it is
// accepted, so loading runs at one element per cycle. Elements beyond
// MAX_ELEMS are dropped; a last flag on a dropped element still ends the vector.
// After the transaction with the last flag, s_ready drops and the original
// positions stream out on the m_ channel in ascending order of
// (primary key, secondary key, position), one rank per cycle while the
// receiver is ready, the final one flagged by last_rank. The first rank
// enters the result register once the controller is in its emit state. A
// stall on m_ready holds the result register and pauses the emission;
// s_ready returns once the final rank has entered the result register, so
// loading of the next vector overlaps it.
// Reset (aresetn low, synchronous) empties the row and returns to loading.
module two_key_index_sort #(
    parameter int MAX_ELEMS = tkis_pkg::MAX_ELEMS_DEF,
    parameter int KEY_WIDTH = tkis_pkg::KEY_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tkis_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output tkis_pkg::out_t m_payload
);

    tkis_pkg::cmd_t    cmd;
    tkis_pkg::status_t status;

    tkis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_payload.last_element),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    tkis_datapath #(
        .MAX_ELEMS (MAX_ELEMS),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
